// File: hdl/id_allow_list_table_macros.svh
// Assertion macros for the checker file.
`ifndef ID_ALLOW_LIST_TABLE_MACROS_SVH
`define ID_ALLOW_LIST_TABLE_MACROS_SVH

// Clocked assertion, masked while reset is high.
`define IAL_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define IAL_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

// File: hdl/ial_pkg.sv
// Types and constants of the identifier allow-list table.
package ial_pkg;

  localparam int ID_W  = 32;
  localparam int CNT_W = 8;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_VERIFY = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef struct packed {
    op_t               opcode;
    logic [ID_W-1:0]   card_id;
  } req_t;

  typedef struct packed {
    logic              status;
    logic [CNT_W-1:0]  entry_count;
  } rsp_t;

endpackage

// File: hdl/id_allow_list_table.sv
// Steps from accept to the result register: a clear goes straight to the result; a search
// reads and compares each stored entry in turn, then ends on a hit or passes through a miss
// step; a remove then reads each entry above the match and writes it back one place down.
// Throughput: one item at a time; the next item is taken the cycle after the result
// moves to the output register, while that result waits there.
// Reset: entry count zero, output empty; RAM contents are not cleared.
module id_allow_list_table
  import ial_pkg::*;
#(
  parameter int MAX_ENTRIES = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req_data,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp_data
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  logic            res_valid;
  logic            res_ready;
  rsp_t            res_data;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [ID_W-1:0] mem_wdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;
  logic [ID_W-1:0] mem_rdata;

  assign res_ready = !rsp_valid || rsp_ready;

  ial_seq #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_data (req_data),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_data (res_data),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_re   (mem_re),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  ial_ram #(
    .WIDTH(ID_W),
    .DEPTH(MAX_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // hold the result beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_ready) begin
      rsp_valid <= res_valid;
    end
    if (res_ready && res_valid) begin
      rsp_data <= res_data;
    end
  end

endmodule

// File: hdl/ial_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ial_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/ial_seq.sv
// Sequencer: linear search, append, shift-down removal and entry count.
module ial_seq
  import ial_pkg::*;
#(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                                               clk,
  input  logic                                               rst,
  input  logic                                               req_valid,
  output logic                                               req_ready,
  input  req_t                                               req_data,
  output logic                                               res_valid,
  input  logic                                               res_ready,
  output rsp_t                                               res_data,
  output logic                                               mem_we,
  output logic [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] mem_waddr,
  output logic [ID_W-1:0]                                    mem_wdata,
  output logic                                               mem_re,
  output logic [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] mem_raddr,
  input  logic [ID_W-1:0]                                    mem_rdata
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SCAN = 7'b0000010,
    S_CMP  = 7'b0000100,
    S_MISS = 7'b0001000,
    S_SHRD = 7'b0010000,
    S_SHWR = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic [CNT_W-1:0] idx_inc;
  op_t              op, op_next;
  logic [ID_W-1:0]  id, id_next;
  logic             status, status_next;

  assign idx_inc   = idx + 1'b1;
  assign req_ready = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res_data  = '{status: status, entry_count: count};

  always_comb begin
    state_next  = state;
    count_next  = count;
    idx_next    = idx;
    op_next     = op;
    id_next     = id;
    status_next = status;
    mem_we      = 1'b0;
    mem_waddr   = idx[AW-1:0];
    mem_wdata   = mem_rdata;
    mem_re      = 1'b0;
    mem_raddr   = idx[AW-1:0];
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          op_next  = req_data.opcode;
          id_next  = req_data.card_id;
          idx_next = '0;
          if (req_data.opcode == OP_CLEAR) begin
            count_next  = '0;
            status_next = STATUS_OK;
            state_next  = S_DONE;
          end else if (count == '0) begin
            state_next = S_MISS;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        mem_re     = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        if (mem_rdata == id) begin
          if (op == OP_REMOVE) begin
            state_next = S_SHRD;
          end else begin
            status_next = (op == OP_ADD) ? STATUS_ERR : STATUS_OK;
            state_next  = S_DONE;
          end
        end else if (idx_inc == count) begin
          state_next = S_MISS;
        end else begin
          idx_next   = idx_inc;
          state_next = S_SCAN;
        end
      end
      S_MISS: begin
        if (op == OP_ADD && count < MAX_CNT) begin
          mem_we      = 1'b1;
          mem_waddr   = count[AW-1:0];
          mem_wdata   = id;
          count_next  = count + 1'b1;
          status_next = STATUS_OK;
        end else begin
          status_next = STATUS_ERR;
        end
        state_next = S_DONE;
      end
      S_SHRD: begin
        if (idx_inc >= count) begin
          count_next  = count - 1'b1;
          status_next = STATUS_OK;
          state_next  = S_DONE;
        end else begin
          mem_re     = 1'b1;
          mem_raddr  = idx_inc[AW-1:0];
          state_next = S_SHWR;
        end
      end
      S_SHWR: begin
        mem_we     = 1'b1;
        mem_waddr  = idx[AW-1:0];
        mem_wdata  = mem_rdata;
        idx_next   = idx_inc;
        state_next = S_SHRD;
      end
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    idx    <= idx_next;
    op     <= op_next;
    id     <= id_next;
    status <= status_next;
  end

endmodule

// File: hdl/ial_checker.sv
// Port-level checker for the identifier allow-list table, with its bind.
`include "id_allow_list_table_macros.svh"

module ial_checker
  import ial_pkg::*;
#(
  parameter int MAX_ENTRIES = 16
) (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp_data
);

  `IAL_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !rsp_valid, "result beat after reset")
  `IAL_ASSERT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "result beat dropped or changed")
  `IAL_ASSERT(a_one_at_a_time, clk, rst, req_valid && req_ready |=> !req_ready, "second request taken while busy")
  `IAL_ASSERT(a_count_bound, clk, rst, rsp_valid |-> rsp_data.entry_count <= CNT_W'(MAX_ENTRIES), "entry count above capacity")

endmodule

bind id_allow_list_table ial_checker #(
  .MAX_ENTRIES(MAX_ENTRIES)
) u_ial_checker (
  .clk      (clk),
  .rst      (rst),
  .req_valid(req_valid),
  .req_ready(req_ready),
  .rsp_valid(rsp_valid),
  .rsp_ready(rsp_ready),
  .rsp_data (rsp_data)
);
